// ===== hdl/jsmd_pkg.sv =====
// ----------------------------------------------------------------------------
// jsmd_pkg
// Shared field widths, configuration register indexes and the command and
// result structures of the job-shop schedule decoder.
// ----------------------------------------------------------------------------
package jsmd_pkg;

    localparam int JOB_W      = 5;
    localparam int STEP_W     = 5;
    localparam int MACHINE_W  = 5;
    localparam int DUR_W      = 16;
    localparam int CFG_W      = 6;
    localparam int CFG_ADDR_W = 1;
    localparam int OUT_TIME_W = 32;

    // Number of distinct codes a stored machine field can hold
    localparam int MACHINE_CODES = 2 ** MACHINE_W;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_NUM_JOBS     = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_NUM_MACHINES = 1'b1;

    localparam logic [CFG_W-1:0] NUM_JOBS_RST     = 6'd32;
    localparam logic [CFG_W-1:0] NUM_MACHINES_RST = 6'd32;

    // Input data word: job, step, machine, duration from the lowest bit up
    localparam int S_TDATA_W = 32;
    // Result data word: op_start, op_end, machine_used, makespan
    localparam int M_TDATA_W = 104;

    // Command classified by the front end and queued for the back end
    typedef struct packed {
        logic                 is_load;
        logic                 load_ok;
        logic                 job_ok;
        logic [JOB_W-1:0]     job;
        logic [STEP_W-1:0]    step;
        logic [MACHINE_W-1:0] machine;
        logic [DUR_W-1:0]     duration;
        logic                 last;
    } cmd_t;

    typedef struct packed {
        logic                  is_last;
        logic                  bad_item;
        logic [OUT_TIME_W-1:0] makespan;
        logic [MACHINE_W-1:0]  machine_used;
        logic [OUT_TIME_W-1:0] op_end;
        logic [OUT_TIME_W-1:0] op_start;
    } res_t;

endpackage

// ===== hdl/jsmd_ram.sv =====
// ----------------------------------------------------------------------------
// jsmd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module jsmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/jsmd_front.sv =====
// ----------------------------------------------------------------------------
// jsmd_front
// Input stage: accept a transaction, classify it as load or schedule and
// check its indexes, then hand it to the command queue.
// ----------------------------------------------------------------------------
module jsmd_front #(
    parameter int MAX_JOBS     = 32,
    parameter int MAX_MACHINES = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [jsmd_pkg::CFG_W-1:0]    num_jobs,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [jsmd_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output jsmd_pkg::cmd_t                cmd
);
    import jsmd_pkg::*;

    logic valid_reg;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic [JOB_W-1:0]  job_in;
    logic [STEP_W-1:0] step_in;

    assign job_in  = s_tdata[JOB_W-1:0];
    assign step_in = s_tdata[JOB_W +: STEP_W];

    always_comb begin
        cmd_next.is_load  = !s_tuser;
        cmd_next.load_ok  = (32'(job_in) < 32'(MAX_JOBS)) && (32'(step_in) < 32'(MAX_MACHINES));
        cmd_next.job_ok   = (32'(job_in) < 32'(num_jobs)) && (32'(job_in) < 32'(MAX_JOBS));
        cmd_next.job      = job_in;
        cmd_next.step     = step_in;
        cmd_next.machine  = s_tdata[JOB_W+STEP_W +: MACHINE_W];
        cmd_next.duration = s_tdata[JOB_W+STEP_W+MACHINE_W +: DUR_W];
        cmd_next.last     = s_tlast;
    end

    assign s_tready = !valid_reg || cmd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

// ===== hdl/jsmd_queue.sv =====
// ----------------------------------------------------------------------------
// jsmd_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module jsmd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  jsmd_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output jsmd_pkg::cmd_t pop_cmd
);
    import jsmd_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_cmd    = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hdl/jsmd_back.sv =====
// ----------------------------------------------------------------------------
// jsmd_back
// Execution engine: write loads into the operation table, and for schedule
// commands walk job state, operation table and machine state, then update
// the free times and the makespan and load the result register.
// ----------------------------------------------------------------------------
module jsmd_back #(
    parameter int MAX_JOBS      = 32,
    parameter int MAX_MACHINES  = 32,
    parameter int DURATION_BITS = 16,
    parameter int TIME_BITS     = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [jsmd_pkg::CFG_W-1:0] num_machines,
    input  logic                       q_valid,
    output logic                       q_ready,
    input  jsmd_pkg::cmd_t             q_cmd,
    output logic                       res_valid,
    input  logic                       res_ready,
    output jsmd_pkg::res_t             res
);
    import jsmd_pkg::*;

    localparam int JW    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int MIW   = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
    localparam int SCW   = $clog2(MAX_MACHINES + 1);
    localparam int TDEP  = MAX_JOBS * MAX_MACHINES;
    localparam int TAW   = (TDEP > 1) ? $clog2(TDEP) : 1;
    localparam int DW    = DURATION_BITS;
    localparam int SW    = ((TIME_BITS > DW) ? TIME_BITS : DW) + 1;
    localparam int JRW   = SCW + TIME_BITS;
    localparam int TABW  = MACHINE_W + DW;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_STEP = 2'd1;
    localparam logic [1:0] ST_TAB  = 2'd2;
    localparam logic [1:0] ST_EXEC = 2'd3;

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    // Stored machine code modulo MAX_MACHINES, built by counting
    function automatic logic [MACHINE_CODES*MIW-1:0] mod_tab_f();
        logic [MACHINE_CODES*MIW-1:0] t;
        int r;
        t = '0;
        r = 0;
        for (int i = 0; i < MACHINE_CODES; i++) begin
            t[i*MIW +: MIW] = MIW'(r);
            r = (r + 1 == MAX_MACHINES) ? 0 : r + 1;
        end
        return t;
    endfunction

    localparam logic [MACHINE_CODES*MIW-1:0] MOD_TAB = mod_tab_f();

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [JW-1:0]        job_idx_reg;
    logic                 job_ok_reg;
    logic                 last_reg;
    logic                 good_reg;
    logic [SCW-1:0]       s_reg;
    logic [TIME_BITS-1:0] jfree_reg;
    logic [MACHINE_W-1:0] mach_reg;
    logic [MIW-1:0]       midx_reg;
    logic [DW-1:0]        dur_reg;
    logic [MAX_JOBS-1:0]     job_vld_reg;
    logic [MAX_MACHINES-1:0] mach_vld_reg;
    logic [TIME_BITS-1:0] mk_reg;
    logic                 out_valid_reg;
    res_t                 out_reg;

    // RAM ports
    logic           tab_we;
    logic [TAW-1:0] tab_waddr;
    logic [TABW-1:0] tab_wdata;
    logic           tab_re;
    logic [TAW-1:0] tab_raddr;
    logic [TABW-1:0] tab_rdata;
    logic           j_we;
    logic           j_re;
    logic [JW-1:0]  j_raddr;
    logic [JRW-1:0] j_wdata;
    logic [JRW-1:0] j_rdata;
    logic           m_we;
    logic           m_re;
    logic [MIW-1:0] m_raddr;
    logic [TIME_BITS-1:0] m_rdata;

    // Datapath values
    logic [7:0]           job_ext;
    logic [JW-1:0]        q_job_idx;
    logic [31:0]          dur_ext;
    logic [SCW-1:0]       s_cur;
    logic [TIME_BITS-1:0] jfree_cur;
    logic                 good_cur;
    logic [MACHINE_W-1:0] tab_mach;
    logic [MIW-1:0]       midx_cur;
    logic [TIME_BITS-1:0] mfree;
    logic [TIME_BITS-1:0] start_t;
    logic [SW-1:0]        sum_t;
    logic [TIME_BITS-1:0] end_t;
    logic [TIME_BITS-1:0] mk_new;
    logic [63:0]          start64;
    logic [63:0]          end64;
    logic [63:0]          mk64;
    logic                 out_free;
    logic                 finish;
    res_t                 res_next;

    assign job_ext   = 8'(q_cmd.job);
    assign q_job_idx = job_ext[JW-1:0];
    assign dur_ext   = 32'(q_cmd.duration);

    assign out_free = !out_valid_reg || res_ready;
    assign finish   = (state_reg == ST_EXEC) && out_free;
    assign q_ready  = (state_reg == ST_IDLE);

    // Load path: write one table entry
    assign tab_we    = q_valid && q_ready && q_cmd.is_load && q_cmd.load_ok;
    assign tab_waddr = TAW'(int'(q_job_idx) * MAX_MACHINES + int'(q_cmd.step));
    assign tab_wdata = {q_cmd.machine, dur_ext[DW-1:0]};

    // Job state read on a schedule pop
    assign j_re    = q_valid && q_ready && !q_cmd.is_load;
    assign j_raddr = q_job_idx;

    // Step counter and job free time, unwritten rows read as zero
    always_comb begin
        if (job_vld_reg[job_idx_reg]) begin
            s_cur     = j_rdata[TIME_BITS +: SCW];
            jfree_cur = j_rdata[TIME_BITS-1:0];
        end else begin
            s_cur     = '0;
            jfree_cur = '0;
        end
        good_cur = job_ok_reg && (32'(s_cur) < 32'(num_machines))
                   && (32'(s_cur) < 32'(MAX_MACHINES));
    end

    assign tab_re    = (state_reg == ST_STEP) && good_cur;
    assign tab_raddr = TAW'(int'(job_idx_reg) * MAX_MACHINES + int'(s_cur));

    assign tab_mach = tab_rdata[DW +: MACHINE_W];
    assign midx_cur = MOD_TAB[int'(tab_mach)*MIW +: MIW];
    assign m_re     = (state_reg == ST_TAB) && good_reg;
    assign m_raddr  = midx_cur;

    // Start at the later free time, end saturates at the top of the time range
    always_comb begin
        mfree   = mach_vld_reg[midx_reg] ? m_rdata : '0;
        start_t = (jfree_reg > mfree) ? jfree_reg : mfree;
        sum_t   = SW'(start_t) + SW'(dur_reg);
        end_t   = (sum_t > SW'(TIME_MAX)) ? TIME_MAX : sum_t[TIME_BITS-1:0];
        mk_new  = (good_reg && (end_t > mk_reg)) ? end_t : mk_reg;
        start64 = 64'(start_t);
        end64   = 64'(end_t);
        mk64    = 64'(mk_new);
        res_next.is_last      = last_reg;
        res_next.bad_item     = !good_reg;
        res_next.makespan     = mk64[OUT_TIME_W-1:0];
        res_next.machine_used = good_reg ? mach_reg : '0;
        res_next.op_end       = good_reg ? end64[OUT_TIME_W-1:0] : '0;
        res_next.op_start     = good_reg ? start64[OUT_TIME_W-1:0] : '0;
    end

    assign j_we    = finish && good_reg;
    assign m_we    = finish && good_reg;
    assign j_wdata = {s_reg + SCW'(1), end_t};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid && !q_cmd.is_load) begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: state_next = ST_TAB;
            ST_TAB:  state_next = ST_EXEC;
            ST_EXEC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            job_vld_reg   <= '0;
            mach_vld_reg  <= '0;
            mk_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (finish) begin
                out_valid_reg <= 1'b1;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (finish) begin
                if (last_reg) begin
                    // End of sequence: drop all free times and counters
                    job_vld_reg  <= '0;
                    mach_vld_reg <= '0;
                    mk_reg       <= '0;
                end else begin
                    mk_reg <= mk_new;
                    if (good_reg) begin
                        job_vld_reg[job_idx_reg] <= 1'b1;
                        mach_vld_reg[midx_reg]   <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (j_re) begin
            job_idx_reg <= q_job_idx;
            job_ok_reg  <= q_cmd.job_ok;
            last_reg    <= q_cmd.last;
        end
        if (state_reg == ST_STEP) begin
            s_reg     <= s_cur;
            jfree_reg <= jfree_cur;
            good_reg  <= good_cur;
        end
        if (state_reg == ST_TAB) begin
            mach_reg <= tab_mach;
            midx_reg <= midx_cur;
            dur_reg  <= tab_rdata[DW-1:0];
        end
        if (finish) begin
            out_reg <= res_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    jsmd_ram #(
        .WIDTH (TABW),
        .DEPTH (TDEP)
    ) u_op_tab (
        .aclk  (aclk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .re    (tab_re),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    jsmd_ram #(
        .WIDTH (JRW),
        .DEPTH (MAX_JOBS)
    ) u_job_state (
        .aclk  (aclk),
        .we    (j_we),
        .waddr (job_idx_reg),
        .wdata (j_wdata),
        .re    (j_re),
        .raddr (j_raddr),
        .rdata (j_rdata)
    );

    jsmd_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (MAX_MACHINES)
    ) u_mach_free (
        .aclk  (aclk),
        .we    (m_we),
        .waddr (midx_reg),
        .wdata (end_t),
        .re    (m_re),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

endmodule

// ===== hdl/job_shop_makespan_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// Operation: the back end writes a load transaction into the table as it pops
// it; a schedule transaction steps through job state read, table read,
// machine read and update, three registered RAM reads in order, and the back
// end takes no new command until the update has loaded the result register.
// Reset: synchronous active-low; clears counters, free times, makespan and
// handshake state; the operation table holds whatever was loaded.
// ----------------------------------------------------------------------------
// job_shop_makespan_decoder_unit
// Job-shop semi-active schedule decoder. Load transactions fill the operation
// table; schedule transactions place a job's next operation at the later of
// its machine's and its own free time and report start, end and makespan.
// ----------------------------------------------------------------------------
module job_shop_makespan_decoder_unit #(
    parameter int MAX_JOBS      = 32,
    parameter int MAX_MACHINES  = 32,
    parameter int DURATION_BITS = 16,
    parameter int TIME_BITS     = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write port
    input  logic                             cfg_wr_en,
    input  logic [jsmd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [jsmd_pkg::CFG_W-1:0]       cfg_wdata,
    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [jsmd_pkg::S_TDATA_W-1:0]   s_tdata,  // job, step, machine, duration
    input  logic                             s_tuser,  // func
    input  logic                             s_tlast,  // last
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [jsmd_pkg::M_TDATA_W-1:0]   m_tdata,  // op_start, op_end, machine_used, makespan
    output logic                             m_tuser,  // bad_item
    output logic                             m_tlast   // is_last
);
    import jsmd_pkg::*;

    logic [CFG_W-1:0] num_jobs_reg;
    logic [CFG_W-1:0] num_machines_reg;

    logic fe_valid;
    logic fe_ready;
    cmd_t fe_cmd;
    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;
    logic res_valid;
    res_t res;

    // Configuration registers; the user must write them only while the block is idle, which the block does not enforce
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_jobs_reg     <= NUM_JOBS_RST;
            num_machines_reg <= NUM_MACHINES_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_NUM_JOBS:     num_jobs_reg     <= cfg_wdata;
                CFG_NUM_MACHINES: num_machines_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Front end: accept and classify every transaction
    jsmd_front #(
        .MAX_JOBS     (MAX_JOBS),
        .MAX_MACHINES (MAX_MACHINES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .num_jobs  (num_jobs_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cmd_valid (fe_valid),
        .cmd_ready (fe_ready),
        .cmd       (fe_cmd)
    );

    // Short queue so the front keeps accepting while the back end works
    jsmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fe_valid),
        .push_ready (fe_ready),
        .push_cmd   (fe_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    // Back end: table writes, free-time update, result register
    jsmd_back #(
        .MAX_JOBS      (MAX_JOBS),
        .MAX_MACHINES  (MAX_MACHINES),
        .DURATION_BITS (DURATION_BITS),
        .TIME_BITS     (TIME_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .num_machines (num_machines_reg),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_cmd        (q_cmd),
        .res_valid    (res_valid),
        .res_ready    (m_tready),
        .res          (res)
    );

    // Pack the result transaction: time fields from the lowest bit up
    assign m_tvalid = res_valid;
    assign m_tdata  = {3'b000, res.makespan, res.machine_used, res.op_end, res.op_start};
    assign m_tuser  = res.bad_item;
    assign m_tlast  = res.is_last;

endmodule
